[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers clocked on clk, disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion with a caller-given message
`define CHK_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// assertion with a generic message
`define CHK_ASSERT(lbl, prop) \
	`CHK_ASSERT_MSG(lbl, prop, "afsk port check failed")

`endif

[src/afsk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsk_pkg
// shared types and constants for the afsk nrzi tone modulator
// ----------------------------------------------------------------------------
package afsk_pkg;

	// input action codes
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_START = 2'd2
	} action_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_PACKET_BITS  = 2'd0,
		CFG_BAUD_PERIOD  = 2'd1,
		CFG_MARK_PERIOD  = 2'd2,
		CFG_SPACE_PERIOD = 2'd3
	} cfg_reg_t;

	localparam int SINE_POINTS = 128;
	localparam int SINE_IDX_W  = 7;
	localparam int LEVEL_W     = 7;
	localparam int BITS_W      = 12;
	localparam int BAUD_W      = 16;
	localparam int TONE_W      = 10;
	localparam int CFG_DATA_W  = 16;

	// register reset values
	localparam logic [BITS_W-1:0] PACKET_BITS_RST  = 12'd0;
	localparam logic [BAUD_W-1:0] BAUD_PERIOD_RST  = 16'd833;
	localparam logic [TONE_W-1:0] MARK_PERIOD_RST  = 10'd416;
	localparam logic [TONE_W-1:0] SPACE_PERIOD_RST = 10'd208;

	// one sine period, 128 points, 0..127
	localparam logic [LEVEL_W-1:0] SINE_TAB [SINE_POINTS] = '{
		7'd64, 7'd67, 7'd70, 7'd73, 7'd76, 7'd79, 7'd82, 7'd85,
		7'd88, 7'd91, 7'd93, 7'd96, 7'd99, 7'd101, 7'd104, 7'd106,
		7'd108, 7'd111, 7'd113, 7'd115, 7'd116, 7'd118, 7'd120, 7'd121,
		7'd122, 7'd123, 7'd124, 7'd125, 7'd126, 7'd126, 7'd127, 7'd127,
		7'd127, 7'd127, 7'd127, 7'd126, 7'd126, 7'd125, 7'd124, 7'd123,
		7'd122, 7'd121, 7'd120, 7'd118, 7'd116, 7'd115, 7'd113, 7'd111,
		7'd108, 7'd106, 7'd104, 7'd101, 7'd99, 7'd96, 7'd93, 7'd91,
		7'd88, 7'd85, 7'd82, 7'd79, 7'd76, 7'd73, 7'd70, 7'd67,
		7'd64, 7'd60, 7'd57, 7'd54, 7'd51, 7'd48, 7'd45, 7'd42,
		7'd39, 7'd36, 7'd34, 7'd31, 7'd28, 7'd26, 7'd23, 7'd21,
		7'd19, 7'd16, 7'd14, 7'd12, 7'd11, 7'd9, 7'd7, 7'd6,
		7'd5, 7'd4, 7'd3, 7'd2, 7'd1, 7'd1, 7'd0, 7'd0,
		7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd2, 7'd3, 7'd4,
		7'd5, 7'd6, 7'd7, 7'd9, 7'd11, 7'd12, 7'd14, 7'd16,
		7'd19, 7'd21, 7'd23, 7'd26, 7'd28, 7'd31, 7'd34, 7'd36,
		7'd39, 7'd42, 7'd45, 7'd48, 7'd51, 7'd54, 7'd57, 7'd60
	};

endpackage

[src/afsk_nrzi_tone_modulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsk_nrzi_tone_modulator
// afsk sine generator with nrzi bit coding, packet bytes sent lsb first
// ----------------------------------------------------------------------------
// channel | signals                                    | direction
// --------+--------------------------------------------+----------
// in      | in_valid, in_ready, action, byte_index,    | to block
//         | byte_value                                 |
// out     | out_valid, out_ready, level, active,       | from block
//         | frame_done                                 |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | to block
//
// one transaction per cycle unless stalled: each input is processed in the
// cycle it is taken and its result sits in the output register next cycle.
// the next store byte is prefetched from the packet memory's registered read
// port every cycle, with a bypass for a write to the same entry.
// in_ready drops only while a result waits and out_ready is low.
// reset restores control state and registers; the packet store is not cleared.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module afsk_nrzi_tone_modulator #(
	parameter int STORE_BYTES = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [7:0]                           byte_index,
	input  logic [7:0]                           byte_value,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [afsk_pkg::LEVEL_W-1:0]         level,
	output logic                                 active,
	output logic                                 frame_done,
	// configuration channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [afsk_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	// byte write address modulo the store size, restoring remainder
	function automatic logic [ADDR_W-1:0] store_addr(input logic [7:0] idx);
		logic [ADDR_W:0] rem;
		rem = '0;
		for (int i = 7; i >= 0; i--) begin
			rem = {rem[ADDR_W-1:0], idx[i]};
			if (rem >= (ADDR_W+1)'(STORE_BYTES))
				rem = rem - (ADDR_W+1)'(STORE_BYTES);
		end
		return rem[ADDR_W-1:0];
	endfunction

	// configuration registers
	logic [afsk_pkg::BITS_W-1:0] packet_bits_q;
	logic [afsk_pkg::BAUD_W-1:0] baud_period_q;
	logic [afsk_pkg::TONE_W-1:0] mark_period_q;
	logic [afsk_pkg::TONE_W-1:0] space_period_q;

	// modulator state
	logic                             sending_q, sending_d;
	logic [afsk_pkg::SINE_IDX_W-1:0]  sine_idx_q, sine_idx_d;
	logic [afsk_pkg::TONE_W-1:0]      sample_div_q, sample_div_d;
	logic                             space_sel_q, space_sel_d;
	logic [afsk_pkg::BAUD_W-1:0]      baud_div_q, baud_div_d;
	logic [afsk_pkg::BITS_W-1:0]      bit_pos_q, bit_pos_d;
	logic [7:0]                       shift_byte_q, shift_byte_d;
	logic [afsk_pkg::LEVEL_W-1:0]     level_q, level_d;
	logic [ADDR_W-1:0]                byte_addr_q, byte_addr_d;
	logic                             done_q, done_d;
	logic                             out_valid_q;

	// packet store and prefetch path
	logic [7:0]        store_mem [STORE_BYTES];
	logic [7:0]        rd_data_q;
	logic              fwd_q;
	logic [7:0]        fwd_data_q;
	logic [7:0]        cur_byte;
	logic [7:0]        next_shift;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_en;
	logic              accept;
	logic [afsk_pkg::TONE_W-1:0] tone_limit;
	afsk_pkg::action_t act;

	assign act       = afsk_pkg::action_t'(action);
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign wr_addr   = store_addr(byte_index);
	assign wr_en     = accept && (act == afsk_pkg::ACT_WRITE);
	assign cur_byte  = fwd_q ? fwd_data_q : rd_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_bits_q  <= afsk_pkg::PACKET_BITS_RST;
			baud_period_q  <= afsk_pkg::BAUD_PERIOD_RST;
			mark_period_q  <= afsk_pkg::MARK_PERIOD_RST;
			space_period_q <= afsk_pkg::SPACE_PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (afsk_pkg::cfg_reg_t'(cfg_index))
				afsk_pkg::CFG_PACKET_BITS:  packet_bits_q  <= cfg_data[afsk_pkg::BITS_W-1:0];
				afsk_pkg::CFG_BAUD_PERIOD:  baud_period_q  <= cfg_data;
				afsk_pkg::CFG_MARK_PERIOD:  mark_period_q  <= cfg_data[afsk_pkg::TONE_W-1:0];
				afsk_pkg::CFG_SPACE_PERIOD: space_period_q <= cfg_data[afsk_pkg::TONE_W-1:0];
				default: ;
			endcase
		end
	end

	// next state for one input
	always_comb begin
		sending_d    = sending_q;
		sine_idx_d   = sine_idx_q;
		sample_div_d = sample_div_q;
		space_sel_d  = space_sel_q;
		baud_div_d   = baud_div_q;
		bit_pos_d    = bit_pos_q;
		shift_byte_d = shift_byte_q;
		level_d      = level_q;
		byte_addr_d  = byte_addr_q;
		done_d       = 1'b0;
		tone_limit   = space_sel_q ? space_period_q : mark_period_q;
		next_shift   = (bit_pos_q[2:0] == 3'd0) ? cur_byte : {1'b0, shift_byte_q[7:1]};
		if (accept) begin
			unique case (act)
				afsk_pkg::ACT_TICK: begin
					if (sending_q) begin
						// sample divider and sine step
						if (sample_div_q >= tone_limit) begin
							sample_div_d = '0;
							level_d      = afsk_pkg::SINE_TAB[sine_idx_q];
							sine_idx_d   = sine_idx_q + 1'b1;
						end else begin
							sample_div_d = sample_div_q + 1'b1;
						end
						// baud divider and bit shift-out
						if (baud_div_q < baud_period_q) begin
							baud_div_d = baud_div_q + 1'b1;
						end else begin
							baud_div_d = '0;
							if (bit_pos_q >= packet_bits_q) begin
								sending_d = 1'b0;
								done_d    = 1'b1;
							end else begin
								shift_byte_d = next_shift;
								// nrzi: zero bit flips the tone
								if (!next_shift[0])
									space_sel_d = !space_sel_q;
								bit_pos_d = bit_pos_q + 1'b1;
								if (bit_pos_q[2:0] == 3'd7)
									byte_addr_d = (byte_addr_q == LAST_ADDR) ?
										'0 : byte_addr_q + 1'b1;
							end
						end
					end
				end
				afsk_pkg::ACT_START: begin
					bit_pos_d   = '0;
					byte_addr_d = '0;
					space_sel_d = 1'b0;
					sending_d   = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q    <= 1'b0;
			sine_idx_q   <= '0;
			sample_div_q <= '0;
			space_sel_q  <= 1'b0;
			baud_div_q   <= '0;
			bit_pos_q    <= '0;
			shift_byte_q <= '0;
			level_q      <= '0;
			byte_addr_q  <= '0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			fwd_q        <= 1'b0;
		end else begin
			sending_q    <= sending_d;
			sine_idx_q   <= sine_idx_d;
			sample_div_q <= sample_div_d;
			space_sel_q  <= space_sel_d;
			baud_div_q   <= baud_div_d;
			bit_pos_q    <= bit_pos_d;
			shift_byte_q <= shift_byte_d;
			level_q      <= level_d;
			byte_addr_q  <= byte_addr_d;
			if (accept)
				done_q <= done_d;
			if (in_ready)
				out_valid_q <= in_valid;
			// bypass a write that lands on the entry being prefetched
			fwd_q <= wr_en && (wr_addr == byte_addr_d);
		end
	end

	// packet store: write port and registered prefetch read
	always_ff @(posedge clk) begin
		if (wr_en)
			store_mem[wr_addr] <= byte_value;
		rd_data_q  <= store_mem[byte_addr_d];
		fwd_data_q <= byte_value;
	end

	assign out_valid  = out_valid_q;
	assign level      = level_q;
	assign active     = sending_q;
	assign frame_done = done_q;

endmodule

[src/afsk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsk_checker
// port-level checks on the afsk nrzi tone modulator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module afsk_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [1:0]                       action,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [afsk_pkg::LEVEL_W-1:0]     level,
	input logic                             active,
	input logic                             frame_done
);

	logic in_take;
	logic is_tick;
	logic is_start;

	assign in_take  = in_valid && in_ready;
	assign is_tick  = (action == afsk_pkg::ACT_TICK);
	assign is_start = (action == afsk_pkg::ACT_START);

	// a frame ends with the modulator idle
	`CHK_ASSERT(done_ends_frame, out_valid && frame_done |-> !active)

	// start yields an active result with no done pulse
	`CHK_ASSERT_MSG(start_activates, in_take && is_start |=> out_valid && active && !frame_done, "start did not raise active")

	// non-tick transactions leave the sine level alone
	`CHK_ASSERT_MSG(level_holds, in_take && !is_tick |=> out_valid && !frame_done && level == $past(level), "level moved without a tick")

	// a stalled result holds
	`CHK_ASSERT(out_stall_hold, out_valid && !out_ready |=> out_valid && $stable(level) && $stable(active) && $stable(frame_done))

endmodule

bind afsk_nrzi_tone_modulator afsk_checker u_afsk_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.action     (action),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.level      (level),
	.active     (active),
	.frame_done (frame_done)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the afsk nrzi tone modulator. commands (ticks, byte
// writes, starts, spare codes) are queued by a stimulus process and driven on
// the input channel with random gaps. every accepted command runs through a
// local model of the sine stepper and nrzi bit shifter, and each output
// transaction is compared field by field with the oldest predicted sample.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          STORE_DEPTH = 256;
	localparam int          LONG_HOLD   = 200;
	localparam int          CYCLE_LIMIT = 1000000;
	// spare action code, ignored by the block
	localparam logic [1:0]  ACT_SPARE   = 2'd3;

	typedef logic [7:0]                        byte_t;
	typedef logic [afsk_pkg::BITS_W-1:0]       bits_val_t;
	typedef logic [afsk_pkg::BAUD_W-1:0]       baud_val_t;
	typedef logic [afsk_pkg::TONE_W-1:0]       tone_val_t;
	typedef logic [afsk_pkg::CFG_DATA_W-1:0]   cfg_val_t;

	typedef struct packed {
		logic [1:0] act;
		logic [7:0] idx;
		logic [7:0] val;
	} tone_cmd_t;

	typedef struct packed {
		logic [afsk_pkg::LEVEL_W-1:0] level;
		logic                         active;
		logic                         done;
	} tone_sample_t;

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            in_valid    = 1'b0;
	logic                            in_ready;
	logic [1:0]                      action      = 2'd0;
	logic [7:0]                      byte_index  = 8'd0;
	logic [7:0]                      byte_value  = 8'd0;
	logic                            out_valid;
	logic                            out_ready   = 1'b0;
	logic [afsk_pkg::LEVEL_W-1:0]    level;
	logic                            active;
	logic                            frame_done;
	logic                            cfg_valid   = 1'b0;
	logic                            cfg_ready;
	logic [1:0]                      cfg_index   = 2'd0;
	logic [afsk_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

	tone_cmd_t    pending_cmds[$];
	tone_sample_t expected_samples[$];
	int unsigned  cmds_issued  = 0;
	int unsigned  cmds_taken   = 0;
	int unsigned  fail_count   = 0;
	int unsigned  cycle_count  = 0;
	int unsigned  hold_orders  = 0;
	int unsigned  holds_served = 0;
	int unsigned  gap_left     = 0;
	int unsigned  stall_left   = 0;
	logic         no_gaps      = 1'b0;
	bit           store_written[STORE_DEPTH];

	// predicted block state and registers
	logic [afsk_pkg::BITS_W-1:0]     reg_bits;
	logic [afsk_pkg::BAUD_W-1:0]     reg_baud;
	logic [afsk_pkg::TONE_W-1:0]     reg_mark;
	logic [afsk_pkg::TONE_W-1:0]     reg_space;
	logic [7:0]                      store_mem [STORE_DEPTH];
	logic                            tx_on;
	logic [afsk_pkg::SINE_IDX_W-1:0] sine_idx;
	logic [afsk_pkg::TONE_W-1:0]     samp_div;
	logic                            tone_space;
	logic [afsk_pkg::BAUD_W-1:0]     baud_div;
	logic [afsk_pkg::BITS_W-1:0]     bit_pos;
	logic [7:0]                      shift_reg;
	logic [afsk_pkg::LEVEL_W-1:0]    level_q;

	afsk_nrzi_tone_modulator #(
		.STORE_BYTES(STORE_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.byte_index(byte_index),
		.byte_value(byte_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level     (level),
		.active    (active),
		.frame_done(frame_done),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short pauses, now and then a long one
	function automatic int unsigned pick_pause();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// one command through the modulator model, result appended to the queue
	task automatic advance_tone(input logic [1:0] act, input logic [7:0] idx,
			input logic [7:0] val);
		logic [afsk_pkg::TONE_W-1:0] limit;
		logic                        done;
		tone_sample_t                smp;
		done = 1'b0;
		case (act)
			afsk_pkg::ACT_TICK: begin
				if (tx_on) begin
					// sample divider first
					limit = tone_space ? reg_space : reg_mark;
					if (samp_div >= limit) begin
						samp_div = '0;
						level_q  = afsk_pkg::SINE_TAB[sine_idx];
						sine_idx = sine_idx + 1'b1;
					end else begin
						samp_div = samp_div + 1'b1;
					end
					// then the baud divider
					if (baud_div < reg_baud) begin
						baud_div = baud_div + 1'b1;
					end else begin
						baud_div = '0;
						if (bit_pos >= reg_bits) begin
							tx_on = 1'b0;
							done  = 1'b1;
						end else begin
							if (bit_pos[2:0] == 3'd0)
								shift_reg = store_mem[bit_pos[11:3] % STORE_DEPTH];
							else
								shift_reg = shift_reg >> 1;
							// nrzi: a zero bit flips the tone
							if (!shift_reg[0]) tone_space = !tone_space;
							bit_pos = bit_pos + 1'b1;
						end
					end
				end
			end
			afsk_pkg::ACT_WRITE: store_mem[idx % STORE_DEPTH] = val;
			afsk_pkg::ACT_START: begin
				bit_pos    = '0;
				tone_space = 1'b0;
				tx_on      = 1'b1;
			end
			default: ;
		endcase
		smp.level  = level_q;
		smp.active = tx_on;
		smp.done   = done;
		expected_samples.push_back(smp);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		tone_cmd_t cmd;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			action     <= afsk_pkg::ACT_TICK;
			byte_index <= 8'd0;
			byte_value <= 8'd0;
			gap_left   <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() != 0) begin
				cmd = pending_cmds.pop_front();
				action     <= cmd.act;
				byte_index <= cmd.idx;
				byte_value <= cmd.val;
				in_valid   <= 1'b1;
				gap_left   <= (no_gaps || $urandom_range(0, 99) >= 20) ? 0 : pick_pause();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with random stalls and ordered long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready    <= 1'b0;
			stall_left   <= 0;
			holds_served <= 0;
		end else if (holds_served != hold_orders) begin
			holds_served <= hold_orders;
			stall_left   <= LONG_HOLD;
			out_ready    <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
			stall_left <= pick_pause() - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: register writes, accepted commands, result checks
	always @(posedge clk or negedge arst_n) begin : tone_monitor
		tone_sample_t want;
		if (!arst_n) begin
			reg_bits   = afsk_pkg::PACKET_BITS_RST;
			reg_baud   = afsk_pkg::BAUD_PERIOD_RST;
			reg_mark   = afsk_pkg::MARK_PERIOD_RST;
			reg_space  = afsk_pkg::SPACE_PERIOD_RST;
			tx_on      = 1'b0;
			sine_idx   = '0;
			samp_div   = '0;
			tone_space = 1'b0;
			baud_div   = '0;
			bit_pos    = '0;
			shift_reg  = '0;
			level_q    = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					afsk_pkg::CFG_PACKET_BITS:  reg_bits  = cfg_data[afsk_pkg::BITS_W-1:0];
					afsk_pkg::CFG_BAUD_PERIOD:  reg_baud  = cfg_data[afsk_pkg::BAUD_W-1:0];
					afsk_pkg::CFG_MARK_PERIOD:  reg_mark  = cfg_data[afsk_pkg::TONE_W-1:0];
					afsk_pkg::CFG_SPACE_PERIOD: reg_space = cfg_data[afsk_pkg::TONE_W-1:0];
					default: ;
				endcase
			end
			// compare before predicting so a result can never match its own command
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					$error("unexpected result transaction: level %0d active %0b done %0b",
						level, active, frame_done);
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					if (level !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, level);
						fail_count++;
					end
					if (active !== want.active) begin
						$error("active: expected %0b, got %0b", want.active, active);
						fail_count++;
					end
					if (frame_done !== want.done) begin
						$error("frame_done: expected %0b, got %0b", want.done, frame_done);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				advance_tone(action, byte_index, byte_value);
				cmds_taken++;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic push_cmd(input logic [1:0] act, input logic [7:0] idx,
			input logic [7:0] val);
		tone_cmd_t cmd;
		cmd.act = act;
		cmd.idx = idx;
		cmd.val = val;
		if (act == afsk_pkg::ACT_WRITE) store_written[idx % STORE_DEPTH] = 1'b1;
		pending_cmds.push_back(cmd);
		cmds_issued++;
	endtask

	task automatic push_ticks(input int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			push_cmd(afsk_pkg::ACT_TICK, byte_t'($urandom_range(0, 255)),
				byte_t'($urandom_range(0, 255)));
	endtask

	// make sure every byte a frame of this length can load has been written
	task automatic fill_store(input int unsigned nbits);
		for (int unsigned e = 0; e < (nbits + 7) / 8; e++)
			if (!store_written[e % STORE_DEPTH])
				push_cmd(afsk_pkg::ACT_WRITE, byte_t'(e), byte_t'($urandom_range(0, 255)));
	endtask

	// call at a clock edge; leaves cfg_valid high for a following write
	task automatic write_reg(input afsk_pkg::cfg_reg_t idx,
			input logic [afsk_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [afsk_pkg::BITS_W-1:0] bits,
			input logic [afsk_pkg::BAUD_W-1:0] baud,
			input logic [afsk_pkg::TONE_W-1:0] mark,
			input logic [afsk_pkg::TONE_W-1:0] space);
		write_reg(afsk_pkg::CFG_PACKET_BITS, cfg_val_t'(bits));
		write_reg(afsk_pkg::CFG_BAUD_PERIOD, baud);
		write_reg(afsk_pkg::CFG_MARK_PERIOD, cfg_val_t'(mark));
		write_reg(afsk_pkg::CFG_SPACE_PERIOD, cfg_val_t'(space));
		cfg_valid <= 1'b0;
	endtask

	// returns at a clock edge once every command is taken and checked
	task automatic wait_drained();
		@(posedge clk);
		while (cmds_taken != cmds_issued || expected_samples.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [afsk_pkg::TONE_W-1:0] pick_tone_period();
		if ($urandom_range(0, 7) == 0) return tone_val_t'($urandom_range(16, 1023));
		return tone_val_t'($urandom_range(0, 15));
	endfunction

	// random frame: fresh settings, store filled, start, then mixed traffic
	task automatic random_phase(input logic quiet, input bit long_hold);
		logic [afsk_pkg::BITS_W-1:0] bits;
		logic [afsk_pkg::BAUD_W-1:0] baud;
		int unsigned                 n;
		int unsigned                 r;
		logic [7:0]                  idx;
		bits = bits_val_t'(($urandom_range(0, 9) == 0) ?
			$urandom_range(25, 200) : $urandom_range(0, 24));
		baud = baud_val_t'(($urandom_range(0, 4) == 0) ?
			$urandom_range(4, 40) : $urandom_range(0, 3));
		set_config(bits, baud, pick_tone_period(), pick_tone_period());
		no_gaps <= quiet;
		if (long_hold) hold_orders <= hold_orders + 1;
		fill_store(bits);
		push_cmd(afsk_pkg::ACT_START, byte_t'($urandom_range(0, 255)),
			byte_t'($urandom_range(0, 255)));
		n = $urandom_range(60, 90);
		for (int unsigned k = 0; k < n; k++) begin
			r   = $urandom_range(0, 99);
			idx = byte_t'($urandom_range(0, 255));
			if (r < 80)
				push_cmd(afsk_pkg::ACT_TICK, idx, byte_t'($urandom_range(0, 255)));
			else if (r < 92)
				push_cmd(afsk_pkg::ACT_WRITE, idx, byte_t'($urandom_range(0, 255)));
			else if (r < 97)
				push_cmd(afsk_pkg::ACT_START, idx, byte_t'($urandom_range(0, 255)));
			else
				push_cmd(ACT_SPARE, idx, byte_t'($urandom_range(0, 255)));
		end
		wait_drained();
	endtask

	// stimulus
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero periods everywhere but space; idle tick, spare code, field extremes,
		// a write into a byte not yet loaded, and a restart mid-frame
		set_config(12'd16, 16'd0, 10'd0, 10'd3);
		push_cmd(afsk_pkg::ACT_TICK, 8'd0, 8'd0);
		push_cmd(ACT_SPARE, 8'hFF, 8'hFF);
		push_cmd(afsk_pkg::ACT_WRITE, 8'd0, 8'h00);
		push_cmd(afsk_pkg::ACT_WRITE, 8'd1, 8'hFF);
		push_cmd(afsk_pkg::ACT_WRITE, 8'hFF, 8'hFF);
		push_cmd(afsk_pkg::ACT_START, 8'd0, 8'd0);
		push_ticks(3);
		push_cmd(afsk_pkg::ACT_WRITE, 8'd1, 8'h5A);
		push_cmd(afsk_pkg::ACT_START, 8'hFF, 8'hFF);
		push_ticks(18);
		wait_drained();

		// frame length lowered below the current bit position
		set_config(12'd64, 16'd2, 10'd5, 10'd1);
		fill_store(64);
		push_cmd(afsk_pkg::ACT_START, 8'd0, 8'd0);
		push_ticks(30);
		wait_drained();
		set_config(12'd4, 16'd2, 10'd5, 10'd1);
		push_ticks(5);
		wait_drained();

		// empty frame ends on the first tick; then slowest baud left running
		set_config(12'd0, 16'd0, 10'd1023, 10'd1023);
		push_cmd(afsk_pkg::ACT_START, 8'd0, 8'd0);
		push_ticks(2);
		wait_drained();
		set_config(12'd0, 16'hFFFF, 10'd1023, 10'd0);
		push_cmd(afsk_pkg::ACT_START, 8'd0, 8'd0);
		push_ticks(100);
		wait_drained();

		// random frames; the next one lowers the baud period under the divider
		for (int p = 0; p < 6; p++)
			random_phase(p % 4 == 3, p == 5);

		// long frame at the fastest baud, bit every tick
		set_config(12'd256, 16'd0, 10'd7, 10'd3);
		no_gaps <= 1'b1;
		fill_store(256);
		push_cmd(afsk_pkg::ACT_START, 8'd0, 8'd0);
		push_ticks(264);
		wait_drained();

		// a last random frame back at normal pacing
		random_phase(1'b0, 1'b1);

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/afsk_pkg.sv
src/afsk_nrzi_tone_modulator.sv
src/afsk_checker.sv
sim/tb_top.sv
